// ===== rtl/core/cp437_pkg.sv =====
// ----------------------------------------------------------------------------
// cp437_pkg
// Shared constants, tables and types of the text-cell to terminal encoder.
// ----------------------------------------------------------------------------
package cp437_pkg;

    localparam int GFX_SPAN      = 43;
    localparam int MAX_BYTES     = 14;
    localparam int SGR_BYTES     = 10;
    localparam int CS_BYTES      = 3;

    localparam logic [7:0] GFX_FIRST_RESET = 8'd176;
    localparam logic [7:0] ATTR_RESET      = 8'hFF;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_M      = 8'h6D;

    // Frame of bytes for one character, index 0 goes out first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [3:0]                len;
    } frame_t;

    // Encoder result: the frame and the state update for the kept settings.
    typedef struct packed {
        frame_t     frame;
        logic       gfx_next;
        logic       attr_write;
    } enc_result_t;

    // DEC special-graphics letter for each entry of the box-drawing range.
    function automatic logic [7:0] dec_gfx_lookup(input logic [5:0] offset);
        logic [7:0] ch;
        unique case (offset)
            6'd0,  6'd1,  6'd2:                          ch = 8'h61;
            6'd3,  6'd10:                                ch = 8'h78;
            6'd4,  6'd5,  6'd6,  6'd9:                   ch = 8'h75;
            6'd7,  6'd8,  6'd11, 6'd15:                  ch = 8'h6B;
            6'd12, 6'd13, 6'd14, 6'd41:                  ch = 8'h6A;
            6'd16, 6'd24, 6'd35, 6'd36:                  ch = 8'h6D;
            6'd17, 6'd26, 6'd31, 6'd32:                  ch = 8'h76;
            6'd18, 6'd27, 6'd33, 6'd34:                  ch = 8'h77;
            6'd19, 6'd22, 6'd23, 6'd28:                  ch = 8'h74;
            6'd20, 6'd29:                                ch = 8'h71;
            6'd21, 6'd30, 6'd39, 6'd40:                  ch = 8'h6E;
            6'd25, 6'd37, 6'd38, 6'd42:                  ch = 8'h6C;
            default:                                     ch = 8'h61;
        endcase
        return ch;
    endfunction

    // RGB bit order of the text mode to ANSI colour number, as an ASCII digit.
    function automatic logic [7:0] colour_digit(input logic [2:0] rgb);
        logic [2:0] ansi;
        ansi = {rgb[0], rgb[1], rgb[2]};
        return {5'b00110, ansi};
    endfunction

endpackage

// ===== rtl/core/cp437_if.sv =====
// ----------------------------------------------------------------------------
// cp437 channel interfaces
// Valid/ready channels for character cells, output bytes and configuration.
// ----------------------------------------------------------------------------
interface cp437_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [7:0] attribute;

    modport source (output valid, output char_code, output attribute, input ready);
    modport sink   (input valid, input char_code, input attribute, output ready);
endinterface

interface cp437_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

interface cp437_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] graphics_first_code;

    modport source (output valid, output graphics_first_code, input ready);
    modport sink   (input valid, input graphics_first_code, output ready);
endinterface

// ===== rtl/core/cp437_to_ansi_escape_encoder_top.sv =====
// ----------------------------------------------------------------------------
// cp437_to_ansi_escape_encoder_top
// Text-mode character cell to VT100/ANSI byte stream encoder.
// ----------------------------------------------------------------------------
// The first byte of a cell is offered in the cycle after the cell is taken.
// The output shift register hands out one byte per cycle while the sink is ready;
//   a cell's byte frame holds 1 to 14 bytes.
// The next cell is taken in the cycle its predecessor's last byte leaves.
// Reset: ASCII charset, attribute 0xFF, box-drawing range starts at code 176.
module cp437_to_ansi_escape_encoder_top
    import cp437_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cp437_in_if.sink    char_in,
    cp437_cfg_if.sink   cfg,
    cp437_out_if.source byte_out
);

    logic        first_code_reg;
    logic [7:0]  first_code_q_reg;
    logic        gfx_active_reg;
    logic [7:0]  kept_attr_reg;
    logic        can_load;
    logic        load;
    enc_result_t enc;

    assign cfg.ready     = 1'b1;
    assign char_in.ready = can_load;
    assign load          = char_in.valid && can_load;

    // Kept settings, and a mark that the range register has been written at least once since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg   <= 1'b0;
            first_code_q_reg <= GFX_FIRST_RESET;
            gfx_active_reg   <= 1'b0;
            kept_attr_reg    <= ATTR_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                first_code_reg   <= 1'b1;
                first_code_q_reg <= cfg.graphics_first_code;
            end
            if (load)
            begin
                gfx_active_reg <= enc.gfx_next;
                if (enc.attr_write)
                begin
                    kept_attr_reg <= char_in.attribute;
                end
            end
        end
    end

    cp437_enc u_enc (
        .char_code  (char_in.char_code),
        .attribute  (char_in.attribute),
        .first_code (first_code_q_reg),
        .gfx_active (gfx_active_reg),
        .kept_attr  (kept_attr_reg),
        .result     (enc)
    );

    cp437_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .frame    (enc.frame),
        .can_load (can_load),
        .byte_out (byte_out)
    );

    // A taken cell always shows its first byte in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> byte_out.valid)
        else $error("cell taken but no byte offered");

    // Every frame holds at least the character and at most the full escape set.
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (enc.frame.len >= 4'd1 && enc.frame.len <= 4'(MAX_BYTES)))
        else $error("frame length out of range");

    // Once the last byte leaves with no new cell, the output goes quiet.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_out.valid && byte_out.ready && byte_out.last_byte && !char_in.valid)
        |=> !byte_out.valid)
        else $error("output valid after last byte");

    // The kept attribute only changes when a cell is taken.
    a_attr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(kept_attr_reg))
        else $error("attribute changed without a cell");

    // A range write always sets the written flag.
    a_cfg_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> first_code_reg)
        else $error("range write not recorded");

endmodule

// ===== rtl/core/cp437_enc.sv =====
// ----------------------------------------------------------------------------
// cp437_enc
// Builds the whole byte frame for one character cell from the kept state.
// ----------------------------------------------------------------------------
module cp437_enc
    import cp437_pkg::*;
(
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [7:0]  first_code,
    input  logic        gfx_active,
    input  logic [7:0]  kept_attr,
    output enc_result_t result
);

    logic                      in_range;
    logic [5:0]                offset;
    logic                      cs_switch;
    logic                      sgr_needed;
    logic [3:0]                sgr_base;
    logic [3:0]                char_pos;
    logic [SGR_BYTES-1:0][7:0] sgr_seq;
    logic [7:0]                ch;

    // The range end is taken in nine bits so it does not wrap past 255.
    assign in_range   = (char_code >= first_code) &&
                        ({1'b0, char_code} <= ({1'b0, first_code} + 9'(GFX_SPAN - 1)));
    assign offset     = 6'(char_code - first_code);
    assign cs_switch  = in_range != gfx_active;
    assign sgr_needed = attribute != kept_attr;
    assign sgr_base   = cs_switch ? 4'(CS_BYTES) : 4'd0;
    assign char_pos   = sgr_base + (sgr_needed ? 4'(SGR_BYTES) : 4'd0);
    assign ch         = in_range ? dec_gfx_lookup(offset) : char_code;

    assign sgr_seq[0] = CH_ESC;
    assign sgr_seq[1] = CH_LBRACK;
    assign sgr_seq[2] = attribute[7] ? CH_ONE : CH_ZERO;
    assign sgr_seq[3] = CH_SEMI;
    assign sgr_seq[4] = CH_THREE;
    assign sgr_seq[5] = colour_digit(attribute[6:4]);
    assign sgr_seq[6] = CH_SEMI;
    assign sgr_seq[7] = CH_FOUR;
    assign sgr_seq[8] = colour_digit(attribute[2:0]);
    assign sgr_seq[9] = CH_M;

    always_comb
    begin
        result.frame.bytes = '0;
        if (cs_switch)
        begin
            result.frame.bytes[0] = CH_ESC;
            result.frame.bytes[1] = CH_LPAREN;
            result.frame.bytes[2] = in_range ? CH_ZERO : CH_B;
        end
        if (sgr_needed)
        begin
            for (int k = 0; k < SGR_BYTES; k++)
            begin
                result.frame.bytes[sgr_base + 4'(k)] = sgr_seq[k];
            end
        end
        result.frame.bytes[char_pos] = ch;
        result.frame.len  = char_pos + 4'd1;
        result.gfx_next   = in_range;
        result.attr_write = sgr_needed;
    end

endmodule

// ===== rtl/core/cp437_ser.sv =====
// ----------------------------------------------------------------------------
// cp437_ser
// Frame register that hands out one byte per word on the output channel.
// ----------------------------------------------------------------------------
module cp437_ser
    import cp437_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  frame_t              frame,
    output logic                can_load,
    cp437_out_if.source         byte_out
);

    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [MAX_BYTES-1:0][7:0] bytes_next;
    logic [3:0]                remaining_reg;
    logic [3:0]                remaining_next;
    logic                      pop;
    logic                      last;

    assign last     = remaining_reg == 4'd1;
    assign pop      = byte_out.valid && byte_out.ready;
    assign can_load = (remaining_reg == 4'd0) || (pop && last);

    assign byte_out.valid     = remaining_reg != 4'd0;
    assign byte_out.out_byte  = bytes_reg[0];
    assign byte_out.last_byte = last;

    always_comb
    begin
        bytes_next     = bytes_reg;
        remaining_next = remaining_reg;
        if (load)
        begin
            bytes_next     = frame.bytes;
            remaining_next = frame.len;
        end
        else if (pop)
        begin
            bytes_next     = bytes_reg >> 8;
            remaining_next = remaining_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 4'd0;
        end
        else
        begin
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text-cell to VT100/ANSI byte-stream encoder.
// Character cells go in through the input channel and the output words are
// compared with a behavioral encoder kept in step with the block. A short
// table of directed cells comes first, followed by random phases under
// several box-drawing range settings, random idling on both sides and one
// long stall of the output.
// ----------------------------------------------------------------------------
module tb;
    import cp437_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 7;
    localparam int PHASE_CELLS    = 50;

    // DEC special-graphics letter for each entry of the box-drawing range, entry 0 first.
    localparam logic [8*GFX_SPAN-1:0] BOX_LETTERS = {
        8'h61, 8'h61, 8'h61, 8'h78, 8'h75, 8'h75, 8'h75, 8'h6b, 8'h6b, 8'h75, 8'h78,
        8'h6b, 8'h6a, 8'h6a, 8'h6a, 8'h6b, 8'h6d, 8'h76, 8'h77, 8'h74, 8'h71, 8'h6e,
        8'h74, 8'h74, 8'h6d, 8'h6c, 8'h76, 8'h77, 8'h74, 8'h71, 8'h6e, 8'h76, 8'h76,
        8'h77, 8'h77, 8'h6d, 8'h6d, 8'h6c, 8'h6c, 8'h6e, 8'h6e, 8'h6a, 8'h6c
    };
    localparam logic [23:0] ANSI_COLOUR = {3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic {ROW_CELL, ROW_SET_FIRST} row_kind_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } term_byte_t;

    // The first word of a cell sits in the highest used byte of the vector.
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [3:0]             len;
    } cell_frame_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  code;
        logic [7:0]  attr;
        cell_frame_t frame;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cp437_in_if  char_if ();
    cp437_cfg_if cfg_if ();
    cp437_out_if byte_if ();

    cp437_to_ansi_escape_encoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_if),
        .cfg      (cfg_if),
        .byte_out (byte_if)
    );

    always #10 clk = ~clk;

    // Shadow of the block's kept settings.
    logic [7:0] box_first;
    logic       charset_gfx;
    logic [7:0] attr_kept;

    term_byte_t  pending_bytes[$];
    stim_row_t   stim_rows[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          tx_idle_on     = 1'b1;
    bit          rx_idle_on     = 1'b1;
    int unsigned rx_hold_len    = 0;

    function automatic void note_mismatch(input string what, input logic [7:0] expv,
                                          input logic [7:0] actv);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $time, what, expv, actv);
    endfunction

    function automatic cell_frame_t frame_add(input cell_frame_t f, input logic [7:0] b);
        f.bytes = {f.bytes[8*MAX_BYTES-9:0], b};
        f.len   = f.len + 4'd1;
        return f;
    endfunction

    function automatic logic [7:0] colour_char(input logic [2:0] rgb);
        return CH_ZERO | {5'b00000, ANSI_COLOUR[3*(7-int'(rgb)) +: 3]};
    endfunction

    // Words one cell produces; advances the shadow settings.
    function automatic cell_frame_t encode_cell(input logic [7:0] code, input logic [7:0] attr);
        cell_frame_t f;
        logic [7:0]  ch;
        int          offset;
        f = '0;
        offset = int'(code) - int'(box_first);
        if (offset >= 0 && offset < GFX_SPAN) begin
            if (!charset_gfx) begin
                f = frame_add(f, CH_ESC);
                f = frame_add(f, CH_LPAREN);
                f = frame_add(f, CH_ZERO);
                charset_gfx = 1'b1;
            end
            ch = BOX_LETTERS[8*(GFX_SPAN-1-offset) +: 8];
        end else begin
            if (charset_gfx) begin
                f = frame_add(f, CH_ESC);
                f = frame_add(f, CH_LPAREN);
                f = frame_add(f, CH_B);
                charset_gfx = 1'b0;
            end
            ch = code;
        end
        if (attr != attr_kept) begin
            f = frame_add(f, CH_ESC);
            f = frame_add(f, CH_LBRACK);
            f = frame_add(f, attr[7] ? CH_ONE : CH_ZERO);
            f = frame_add(f, CH_SEMI);
            f = frame_add(f, CH_THREE);
            f = frame_add(f, colour_char(attr[6:4]));
            f = frame_add(f, CH_SEMI);
            f = frame_add(f, CH_FOUR);
            f = frame_add(f, colour_char(attr[2:0]));
            f = frame_add(f, CH_M);
            attr_kept = attr;
        end
        return frame_add(f, ch);
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] code,
                                    input logic [7:0] attr, input int unsigned len = 0,
                                    input logic [8*MAX_BYTES-1:0] bytes = '0);
        stim_row_t r;
        r.kind        = kind;
        r.code        = code;
        r.attr        = attr;
        r.frame.len   = 4'(len);
        r.frame.bytes = bytes;
        stim_rows.push_back(r);
    endfunction

    // A typed frame with a nonzero length replaces the predicted one.
    task automatic send_cell(input logic [7:0] code, input logic [7:0] attr,
                             input cell_frame_t typed);
        int unsigned gap;
        cell_frame_t f;
        term_byte_t  w;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= code;
        char_if.attribute <= attr;
        do @(posedge clk); while (!char_if.ready);
        f = encode_cell(code, attr);
        if (typed.len != 0)
            f = typed;
        for (int i = 0; i < int'(f.len); i++) begin
            w.value = f.bytes[8*(int'(f.len)-1-i) +: 8];
            w.last  = (i == int'(f.len) - 1);
            pending_bytes.push_back(w);
        end
    endtask

    // Register writes happen only once the block has drained.
    task automatic set_box_first(input logic [7:0] value);
        char_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        cfg_if.valid               <= 1'b1;
        cfg_if.graphics_first_code <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        box_first = value;
    endtask

    initial begin
        cell_frame_t none;
        logic [7:0]  code;
        logic [7:0]  attr;
        logic [7:0]  first_val;
        int          lo;
        int          hi;
        int unsigned sel;

        char_if.valid              <= 1'b0;
        char_if.char_code          <= 8'h00;
        char_if.attribute          <= 8'h00;
        cfg_if.valid               <= 1'b0;
        cfg_if.graphics_first_code <= 8'h00;
        box_first   = GFX_FIRST_RESET;
        charset_gfx = 1'b0;
        attr_kept   = ATTR_RESET;
        none        = '0;
        tx_idle_on  = ($urandom_range(0, 1) != 0);

        // Attribute 0xFF matches the kept one after reset, so no color sequence.
        add_row(ROW_CELL, 8'h41, 8'hFF, 1, {8'h41});
        add_row(ROW_CELL, 8'hB0, 8'hFF, 4, {CH_ESC, CH_LPAREN, CH_ZERO, 8'h61});
        add_row(ROW_CELL, 8'hDA, 8'hFF, 1, {8'h6C});
        add_row(ROW_CELL, 8'hAF, 8'h07, 14, {CH_ESC, CH_LPAREN, CH_B, CH_ESC, CH_LBRACK,
                CH_ZERO, CH_SEMI, CH_THREE, CH_ZERO, CH_SEMI, CH_FOUR, 8'h37, CH_M, 8'hAF});
        add_row(ROW_CELL, 8'h00, 8'h07, 1, {8'h00});
        add_row(ROW_CELL, 8'hDB, 8'h07, 1, {8'hDB});
        add_row(ROW_CELL, 8'hFF, 8'h80, 11, {CH_ESC, CH_LBRACK, CH_ONE, CH_SEMI, CH_THREE,
                CH_ZERO, CH_SEMI, CH_FOUR, CH_ZERO, CH_M, 8'hFF});
        add_row(ROW_CELL, 8'h20, 8'h70);
        // The step from 0x08 to 0x00 changes bit 3 alone and still counts as a change of attribute.
        add_row(ROW_CELL, 8'h41, 8'h08);
        add_row(ROW_CELL, 8'h41, 8'h00);
        add_row(ROW_CELL, 8'hB1, 8'h10);
        add_row(ROW_CELL, 8'hC4, 8'h21);
        add_row(ROW_CELL, 8'hCD, 8'h32);
        add_row(ROW_CELL, 8'h7E, 8'h43);
        add_row(ROW_CELL, 8'hD9, 8'h54);
        add_row(ROW_CELL, 8'hC5, 8'h65);
        add_row(ROW_CELL, 8'h30, 8'h76);
        add_row(ROW_CELL, 8'h42, 8'hFF);
        add_row(ROW_SET_FIRST, 8'd0, 8'h00);
        add_row(ROW_CELL, 8'h00, 8'hFF);
        add_row(ROW_CELL, 8'h2A, 8'h0F);
        add_row(ROW_CELL, 8'h2B, 8'h0F);
        add_row(ROW_SET_FIRST, 8'd213, 8'h00);
        add_row(ROW_CELL, 8'hD5, 8'hF7);
        add_row(ROW_CELL, 8'hFF, 8'hF7);
        add_row(ROW_CELL, 8'hD4, 8'hF7);
        // Above 213 the range is cut off at code 255.
        add_row(ROW_SET_FIRST, 8'd255, 8'h00);
        add_row(ROW_CELL, 8'hFF, 8'h8F);
        add_row(ROW_CELL, 8'hFE, 8'h8F);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_SET_FIRST)
                set_box_first(stim_rows[i].code);
            else
                send_cell(stim_rows[i].code, stim_rows[i].attr, stim_rows[i].frame);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       first_val = GFX_FIRST_RESET;
                1:       first_val = 8'd0;
                3:       first_val = 8'd213;
                4:       first_val = 8'd255;
                5:       first_val = 8'($urandom_range(200, 255));
                default: first_val = 8'($urandom_range(0, 255));
            endcase
            set_box_first(first_val);
            for (int k = 0; k < PHASE_CELLS; k++) begin
                // In phase two the sender never pauses while the output is held off.
                if (k % 20 == 0)
                    tx_idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
                if (p == 2 && k == 5)
                    rx_hold_len = $urandom_range(250, 400);
                lo = int'(box_first);
                hi = (lo + GFX_SPAN - 1 > 255) ? 255 : lo + GFX_SPAN - 1;
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    code = 8'($urandom_range(hi, lo));
                else if (sel < 55) begin
                    case ($urandom_range(0, 3))
                        0:       code = 8'(lo - 1);
                        1:       code = 8'(lo);
                        2:       code = 8'(hi);
                        default: code = 8'(hi + 1);
                    endcase
                end else
                    code = 8'($urandom_range(0, 255));
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    attr = attr_kept;
                else if (sel < 60)
                    attr = 8'hFF;
                else
                    attr = 8'($urandom_range(0, 255));
                send_cell(code, attr, none);
            end
        end

        char_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output side: a random stall before each word while idling is on, and one long hold-off.
    initial begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        forever begin
            if (taken % 25 == 0)
                rx_idle_on = ($urandom_range(0, 3) != 0);
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (rx_hold_len != 0) begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall != 0) begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            byte_if.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && byte_if.valid === 1'b1));
            taken++;
        end
    end

    always @(posedge clk) begin
        term_byte_t w;
        if (rst_n && byte_if.valid && byte_if.ready) begin
            if (pending_bytes.size() == 0)
                note_mismatch("word with none expected", 8'h00, byte_if.out_byte);
            else begin
                w = pending_bytes.pop_front();
                if (byte_if.out_byte !== w.value)
                    note_mismatch("out_byte", w.value, byte_if.out_byte);
                if (byte_if.last_byte !== w.last)
                    note_mismatch("last_byte", {7'b0, w.last}, {7'b0, byte_if.last_byte});
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (char_if.valid && char_if.ready) || (byte_if.valid && byte_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
